// ===== rtl/core/ble_pkg.sv =====
// Shared types, constants and curve tables of the battery level estimator.
package ble_pkg;

	localparam int ADC_W           = 12;
	localparam int MV_W            = 16;
	localparam int PCT_W           = 7;
	localparam int STEP_W          = 7;
	localparam int DVS_W           = 7;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int RATIO_FRAC      = 12;
	localparam int SAMPLES_DEFAULT = 8;

	localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MV  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd3;

	localparam logic [MV_W-1:0]   RST_RATIO   = 16'd8192;
	localparam logic [MV_W-1:0]   RST_MIN_MV  = 16'd3000;
	localparam logic [MV_W-1:0]   RST_MAX_MV  = 16'd4200;
	localparam logic [STEP_W-1:0] RST_STEP    = 7'd5;

	localparam logic [MV_W:0]     PRESENT_MARGIN_MV = 17'd150;
	localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
	localparam logic [STEP_W-1:0] STEP_PASS   = 7'd1;

	// nine-point curve, 4200 mV down to 3400 mV
	localparam int                CURVE_LAST   = 8;
	localparam logic [MV_W-1:0]   CURVE_TOP_MV = 16'd4200;
	localparam logic [MV_W-1:0]   CURVE_BOT_MV = 16'd3400;
	localparam logic [10:0]       INTERP_HALF  = 11'd50;
	// floor(x / 100) == (x * 1311) >> 17 for x below 2100
	localparam logic [10:0]       RECIP_100    = 11'd1311;
	localparam int                RECIP_SHIFT  = 17;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_MUL,
		ST_SCALE,
		ST_CURVE,
		ST_RECIP,
		ST_QLOAD,
		ST_QDIV,
		ST_QMUL,
		ST_OUT
	} ble_state_t;

	typedef struct packed {
		logic ready;
		logic acc_en;
		logic mul_en;
		logic scale_en;
		logic curve_en;
		logic recip_en;
		logic qdiv_start;
		logic qmul_en;
		logic out_load;
	} ble_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic burst_last;
		logic div_busy;
		logic step_small;
		logic out_busy;
	} ble_sts_t;

	function automatic logic [MV_W-1:0] curve_mv(input logic [3:0] i);
		case (i)
			4'd0:    curve_mv = 16'd4200;
			4'd1:    curve_mv = 16'd4100;
			4'd2:    curve_mv = 16'd4000;
			4'd3:    curve_mv = 16'd3900;
			4'd4:    curve_mv = 16'd3800;
			4'd5:    curve_mv = 16'd3700;
			4'd6:    curve_mv = 16'd3600;
			4'd7:    curve_mv = 16'd3500;
			default: curve_mv = 16'd3400;
		endcase
	endfunction

	function automatic logic [PCT_W-1:0] curve_pct(input logic [3:0] i);
		case (i)
			4'd0:    curve_pct = 7'd100;
			4'd1:    curve_pct = 7'd90;
			4'd2:    curve_pct = 7'd80;
			4'd3:    curve_pct = 7'd65;
			4'd4:    curve_pct = 7'd50;
			4'd5:    curve_pct = 7'd30;
			4'd6:    curve_pct = 7'd15;
			4'd7:    curve_pct = 7'd5;
			default: curve_pct = 7'd0;
		endcase
	endfunction

endpackage

// ===== rtl/core/ble_in_if.sv =====
// Sample channel: one ADC pin reading per item.
interface ble_in_if;
	import ble_pkg::*;

	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_mv;

	modport source (output valid, output adc_mv, input ready);
	modport sink   (input valid, input adc_mv, output ready);
endinterface

// ===== rtl/core/ble_out_if.sv =====
// Reading channel: one charge estimate per item.
interface ble_out_if;
	import ble_pkg::*;

	logic             valid;
	logic             ready;
	logic [MV_W-1:0]  battery_mv;
	logic             present;
	logic [PCT_W-1:0] percent;
	logic             changed;

	modport source (output valid, output battery_mv, output present, output percent,
		output changed, input ready);
	modport sink   (input valid, input battery_mv, input present, input percent,
		input changed, output ready);
endinterface

// ===== rtl/core/ble_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ble_div #(
	parameter int DVD_W = ble_pkg::PCT_W + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DVD_W-1:0]          dividend,
	input  logic [ble_pkg::DVS_W-1:0] divisor,
	output logic                      busy,
	output logic [DVD_W-1:0]          quotient
);
	import ble_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] work_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, work_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign busy  = cnt_q != '0;
	assign quotient = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy) begin
			work_q <= {work_q[DVD_W-2:0], fits};
			rem_q  <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

endmodule

// ===== rtl/core/ble_ctrl.sv =====
// Sequencer: sample accumulation, scaling, curve lookup, quantization, hand-off.
module ble_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ble_pkg::ble_sts_t sts,
	output ble_pkg::ble_cmd_t cmd
);
	import ble_pkg::*;

	ble_state_t state_q;
	ble_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC:   if (sts.in_valid && sts.burst_last) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_CURVE;
			ST_CURVE: state_d = ST_RECIP;
			ST_RECIP: state_d = ST_QLOAD;
			ST_QLOAD: state_d = sts.step_small ? ST_OUT : ST_QDIV;
			ST_QDIV:  if (!sts.div_busy) state_d = ST_QMUL;
			ST_QMUL:  state_d = ST_OUT;
			ST_OUT:   if (!sts.out_busy) state_d = ST_ACC;
			default:  state_d = ST_ACC;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_ACC: begin
				cmd.ready  = 1'b1;
				cmd.acc_en = sts.in_valid;
			end
			ST_MUL:   cmd.mul_en = 1'b1;
			ST_SCALE: cmd.scale_en = 1'b1;
			ST_CURVE: cmd.curve_en = 1'b1;
			ST_RECIP: cmd.recip_en = 1'b1;
			ST_QLOAD: cmd.qdiv_start = !sts.step_small;
			ST_QMUL:  cmd.qmul_en = 1'b1;
			ST_OUT:   cmd.out_load = !sts.out_busy;
			default:  cmd = '0;
		endcase
	end

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !sts.div_busy)
		else $error("sample taken while divider busy");

	a_qdiv_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.qdiv_start |=> sts.div_busy)
		else $error("divider did not start on quantizer load");

	a_load_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> cmd.ready)
		else $error("no return to accumulation after hand-off");

endmodule

// ===== rtl/core/ble_dp.sv =====
// Datapath: registers, accumulator, scaling, curve, quantizer and output register.
module ble_dp #(
	parameter int SAMPLES_PER_READING = ble_pkg::SAMPLES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic [ble_pkg::ADC_W-1:0]      adc_mv,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [ble_pkg::MV_W-1:0]       out_mv,
	output logic                           out_present,
	output logic [ble_pkg::PCT_W-1:0]      out_percent,
	output logic                           out_changed,
	input  ble_pkg::ble_cmd_t              cmd,
	output ble_pkg::ble_sts_t              sts
);
	import ble_pkg::*;

	localparam int SUM_W  = ADC_W + $clog2(SAMPLES_PER_READING);
	localparam int IDX_W  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int PROD_W = SUM_W + MV_W;
	localparam int DVD_W  = PROD_W + 1 - RATIO_FRAC;
	localparam logic [PROD_W:0]    RND   = (PROD_W + 1)'(SAMPLES_PER_READING * 2048);
	localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(SAMPLES_PER_READING - 1);
	// floor(x / N) == (x * MEAN_RCP) >> MEAN_SH for every x below 2**DVD_W
	localparam int MEAN_SH = DVD_W + $clog2(SAMPLES_PER_READING);
	localparam int RCP_W   = DVD_W + 2;
	localparam int MP_W    = DVD_W + MEAN_SH;
	localparam longint unsigned RCP_FULL =
		((64'd1 << MEAN_SH) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);
	localparam logic [RCP_W-1:0]   MEAN_RCP = RCP_W'(RCP_FULL);
	localparam int QDVD_W = PCT_W + 1;

	// configuration
	logic [MV_W-1:0]   ratio_q;
	logic [MV_W-1:0]   min_mv_q;
	logic [MV_W-1:0]   max_mv_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RST_RATIO;
			min_mv_q <= RST_MIN_MV;
			max_mv_q <= RST_MAX_MV;
			step_q   <= RST_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATIO:  ratio_q  <= cfg_data;
				REG_MIN_MV: min_mv_q <= cfg_data;
				REG_MAX_MV: max_mv_q <= cfg_data;
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// burst accumulation
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] burst_q;
	logic [SUM_W-1:0] sum_next;
	logic             burst_last;

	assign sum_next   = sum_q + SUM_W'(adc_mv);
	assign burst_last = idx_q == IDX_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (cmd.acc_en) begin
			if (burst_last) begin
				sum_q <= '0;
				idx_q <= '0;
			end else begin
				sum_q <= sum_next;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en && burst_last) begin
			burst_q <= sum_next;
		end
	end

	// scale by the divider ratio
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W:0]   rounded;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(burst_q) * PROD_W'(ratio_q);
		end
	end

	assign rounded = {1'b0, prod_q} + RND;

	// mean over the burst by reciprocal multiply
	logic [MP_W-1:0]  mean_prod;
	logic [DVD_W-1:0] mean_q;

	assign mean_prod = MP_W'(rounded[PROD_W:RATIO_FRAC]) * MP_W'(MEAN_RCP);

	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			mean_q <= mean_prod[MEAN_SH +: DVD_W];
		end
	end

	// step divider
	logic [QDVD_W-1:0] quot;
	logic              div_busy;
	logic [PCT_W:0]    qnum;

	logic [PCT_W-1:0] pct_q;

	assign qnum = {1'b0, pct_q} + {2'b00, step_q[STEP_W-1:1]};

	ble_div #(
		.DVD_W (QDVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.qdiv_start),
		.dividend (qnum),
		.divisor  (step_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	// voltage, presence and curve segment
	logic [MV_W-1:0]  mv_sat;
	logic             present_c;
	logic [3:0]       seg;
	logic [PCT_W-1:0] base_c;
	logic [10:0]      x_c;
	logic [6:0]       offs_mv;
	logic [4:0]       rise;

	assign mv_sat    = (|mean_q[DVD_W-1:MV_W]) ? '1 : mean_q[MV_W-1:0];
	assign present_c = (mv_sat >= min_mv_q) &&
		({1'b0, mv_sat} <= ({1'b0, max_mv_q} + PRESENT_MARGIN_MV));

	always_comb begin
		seg = 4'(CURVE_LAST);
		for (int i = CURVE_LAST; i >= 1; i--) begin
			if (mv_sat >= curve_mv(4'(i))) seg = 4'(i);
		end
	end

	assign offs_mv = 7'(mv_sat - curve_mv(seg));
	assign rise    = 5'(curve_pct(seg - 4'd1) - curve_pct(seg));

	always_comb begin
		if (mv_sat >= CURVE_TOP_MV) begin
			base_c = PCT_MAX;
			x_c    = '0;
		end else if (mv_sat <= CURVE_BOT_MV) begin
			base_c = '0;
			x_c    = '0;
		end else begin
			base_c = curve_pct(seg);
			x_c    = 11'(offs_mv) * 11'(rise) + INTERP_HALF;
		end
	end

	logic [MV_W-1:0]  mv_q;
	logic             present_q;
	logic [PCT_W-1:0] base_q;
	logic [10:0]      x_q;

	always_ff @(posedge clk) begin
		if (cmd.curve_en) begin
			mv_q      <= mv_sat;
			present_q <= present_c;
			base_q    <= base_c;
			x_q       <= x_c;
		end
	end

	// divide the interpolation term by the 100 mV span
	logic [21:0] recip_c;

	assign recip_c = 22'(x_q) * 22'(RECIP_100);

	always_ff @(posedge clk) begin
		if (cmd.recip_en) begin
			pct_q <= base_q + PCT_W'(recip_c >> RECIP_SHIFT);
		end
	end

	// quantize to the display step, cap at full
	logic [14:0]      qprod;
	logic [PCT_W-1:0] qm_q;

	assign qprod = 15'(quot) * 15'(step_q);

	always_ff @(posedge clk) begin
		if (cmd.qmul_en) begin
			qm_q <= (qprod > 15'(PCT_MAX)) ? PCT_MAX : qprod[PCT_W-1:0];
		end
	end

	// result register and change tracking
	logic             step_small;
	logic [PCT_W-1:0] pct_final;
	logic             changed_c;
	logic             out_valid_q;
	logic             last_present_q;
	logic [PCT_W-1:0] last_pct_q;
	logic             first_q;

	assign step_small = step_q <= STEP_PASS;
	assign pct_final  = !present_q ? '0 : (step_small ? pct_q : qm_q);
	assign changed_c  = first_q || (present_q != last_present_q) ||
		(present_q && (pct_final != last_pct_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			last_present_q <= 1'b0;
			last_pct_q     <= '0;
			first_q        <= 1'b1;
		end else begin
			if (cmd.out_load) begin
				out_valid_q    <= 1'b1;
				last_present_q <= present_q;
				last_pct_q     <= pct_final;
				first_q        <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_mv      <= mv_q;
			out_present <= present_q;
			out_percent <= pct_final;
			out_changed <= changed_c;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.in_valid   = in_valid;
	assign sts.burst_last = burst_last;
	assign sts.div_busy   = div_busy;
	assign sts.step_small = step_small;
	assign sts.out_busy   = out_valid_q && !out_ready;

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_present) |-> (out_percent == '0))
		else $error("percent non-zero while absent");

	a_pct_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_percent <= PCT_MAX))
		else $error("percent above full");

	a_first_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && first_q) |=> out_changed)
		else $error("first reading not flagged");

	a_burst_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_en && burst_last) |=> (sum_q == '0 && idx_q == '0))
		else $error("accumulator not cleared at end of burst");

endmodule

// ===== rtl/core/battery_level_estimator.sv =====
// Top level of the battery level estimator: sequencer plus datapath.
//
//  channel    dir  handshake         payload
//  sample     in   valid / ready     adc_mv (12 bit pin mV)
//  reading    out  valid / ready     battery_mv, present, percent, changed
//  cfg        in   cfg_we only       cfg_index (3 bit), cfg_data (16 bit)
//
// Sequence: a sample that does not close a burst is accepted without holding off
// the input. The sample that closes a burst is followed by these steps with the input
// held off: product, mean by reciprocal multiply, curve segment, interpolation,
// quantizer load, the bit-serial step division, step multiply, hand-off.
// With a display step of 0 or 1 the division and step multiply are skipped.
// Reset: asynchronous, active low; registers go to their defaults, the burst is
// empty and the next reading is flagged as changed.
// Stalls: the reading waits in an output register; samples keep being taken
// meanwhile, and only the hand-off of the next reading waits on it being taken.
module battery_level_estimator #(
	parameter int SAMPLES_PER_READING = ble_pkg::SAMPLES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data,
	ble_in_if.sink                         sample,
	ble_out_if.source                      reading
);
	import ble_pkg::*;

	ble_cmd_t cmd;
	ble_sts_t sts;

	// sequencer: holds off samples while a burst result is in work
	ble_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	assign sample.ready = cmd.ready;

	// datapath: registers, accumulator, divider, curve and result register
	ble_dp #(
		.SAMPLES_PER_READING (SAMPLES_PER_READING)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (sample.valid),
		.adc_mv      (sample.adc_mv),
		.out_ready   (reading.ready),
		.out_valid   (reading.valid),
		.out_mv      (reading.battery_mv),
		.out_present (reading.present),
		.out_percent (reading.percent),
		.out_changed (reading.changed),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
